// ===== rtl/core/sabs_pkg.sv =====
`timescale 1ns / 1ps
// shared constants, types and helpers of the sorted array bound search block
package sabs_pkg;

  localparam int DEPTH  = 1024;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int PTR_W  = CNT_W + 1;
  localparam int VAL_W  = 32;
  localparam int IDX_W  = 11;

  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  // all ones reads as -1 in a signed index field
  localparam logic [IDX_W-1:0] IDX_NONE = '1;

  typedef logic signed [VAL_W-1:0] val_t;
  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [CNT_W-1:0] cnt_t;
  typedef logic signed [PTR_W-1:0] ptr_t;
  typedef logic [IDX_W-1:0] idx_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_FINISH
  } state_t;

  // searches that share the read port in turn
  typedef enum logic [1:0] {
    SRCH_LB,
    SRCH_UB,
    SRCH_HIT
  } srch_t;

  // probe index (lo+hi)/2, both ends non-negative while a search runs
  function automatic addr_t mid_of(ptr_t lo, ptr_t hi);
    logic [PTR_W:0] s;
    s = {1'b0, lo} + {1'b0, hi};
    return s[ADDR_W:1];
  endfunction

  function automatic ptr_t addr_to_ptr(addr_t a);
    return {{(PTR_W - ADDR_W){1'b0}}, a};
  endfunction

  function automatic idx_t addr_to_idx(addr_t a);
    return {{(IDX_W - ADDR_W){1'b0}}, a};
  endfunction

endpackage

// ===== rtl/core/sabs_req_if.sv =====
`timescale 1ns / 1ps
// request channel: load or query items
interface sabs_req_if;
  import sabs_pkg::*;

  logic valid;
  logic ready;
  logic kind;
  logic start_new;
  val_t value;

  modport source(output valid, output kind, output start_new, output value, input ready);
  modport sink(input valid, input kind, input start_new, input value, output ready);
endinterface

// ===== rtl/core/sabs_rsp_if.sv =====
`timescale 1ns / 1ps
// result channel: one search result per query
interface sabs_rsp_if;
  import sabs_pkg::*;

  logic valid;
  logic ready;
  idx_t hit_index;
  idx_t lower_bound;
  idx_t upper_bound;
  logic floor_found;
  val_t floor_value;
  logic ceil_found;
  val_t ceil_value;
  idx_t first_index;
  idx_t last_index;
  idx_t match_count;

  modport source(
    output valid, output hit_index, output lower_bound, output upper_bound,
    output floor_found, output floor_value, output ceil_found, output ceil_value,
    output first_index, output last_index, output match_count, input ready
  );
  modport sink(
    input valid, input hit_index, input lower_bound, input upper_bound,
    input floor_found, input floor_value, input ceil_found, input ceil_value,
    input first_index, input last_index, input match_count, output ready
  );
endinterface

// ===== rtl/core/sorted_array_bound_search.sv =====
`timescale 1ns / 1ps
// Sorted array bound search. Load requests append one signed element to a 1024-entry
// on-chip array (start_new empties it first; loads beyond the capacity are dropped).
// A query request runs three binary searches over the loaded elements: a lower-bound
// pass (which also yields ceil and first occurrence), an upper-bound pass (which also
// yields floor and last occurrence) and a plain exact-hit pass. The three passes share
// the array's single read port in turn, one probe each per round. A finished result
// sits in an output register, so the next request is taken while it waits to be read.
module sorted_array_bound_search (
  input  logic clk,
  input  logic rst,
  sabs_req_if.sink   req,
  sabs_rsp_if.source rsp
);
  import sabs_pkg::*;

  // element array and its read port
  val_t  mem [DEPTH];
  addr_t wr_addr;
  logic  wr_en;
  addr_t rd_addr;
  val_t  rdata;

  state_t state, state_next;
  cnt_t   count;
  val_t   target;
  srch_t  phase;

  // per-search window
  ptr_t lo_lb, hi_lb, lo_ub, hi_ub, lo_hit, hi_hit;

  // probe in flight
  logic  pend_valid;
  srch_t pend_id;
  addr_t pend_mid;

  // partial results
  logic  lb_found, ub_found, fl_found, hit_found, first_found, last_found;
  addr_t lb_idx, ub_idx, hit_idx, first_idx, last_idx;
  val_t  ceil_val, floor_val;

  logic  accept, load_req, query_start, res_load;
  logic  act_lb, act_ub, act_hit, sel_act, issue, all_done;
  addr_t mid_lb, mid_ub, mid_hit, sel_mid;
  ptr_t  pend_ptr;
  idx_t  cnt_idx;

  assign accept      = req.valid && req.ready;
  assign load_req    = accept && (req.kind == KIND_LOAD);
  assign query_start = accept && (req.kind == KIND_QUERY);

  // window state of each search
  assign act_lb  = (lo_lb <= hi_lb);
  assign act_ub  = (lo_ub <= hi_ub);
  assign act_hit = (lo_hit <= hi_hit) && !hit_found;
  assign mid_lb  = mid_of(lo_lb, hi_lb);
  assign mid_ub  = mid_of(lo_ub, hi_ub);
  assign mid_hit = mid_of(lo_hit, hi_hit);
  assign pend_ptr = addr_to_ptr(pend_mid);
  assign cnt_idx  = IDX_W'(count);

  // round-robin slot owner
  always_comb begin
    case (phase)
      SRCH_LB: begin
        sel_act = act_lb;
        sel_mid = mid_lb;
      end
      SRCH_UB: begin
        sel_act = act_ub;
        sel_mid = mid_ub;
      end
      SRCH_HIT: begin
        sel_act = act_hit;
        sel_mid = mid_hit;
      end
      default: begin
        sel_act = 1'b0;
        sel_mid = mid_lb;
      end
    endcase
  end

  assign issue    = (state == ST_SEARCH) && sel_act;
  assign all_done = !act_lb && !act_ub && !act_hit && !pend_valid;
  assign rd_addr  = sel_mid;

  // write side of the array
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = count[ADDR_W-1:0];
    if (load_req) begin
      if (req.start_new) begin
        wr_en   = 1'b1;
        wr_addr = '0;
      end else if (count < cnt_t'(DEPTH)) begin
        wr_en = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= req.value;
    end
    rdata <= mem[rd_addr];
  end

  // element count
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (load_req) begin
      if (req.start_new) begin
        count <= cnt_t'(1);
      end else if (count < cnt_t'(DEPTH)) begin
        count <= count + cnt_t'(1);
      end
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (query_start) state_next = ST_SEARCH;
      end
      ST_SEARCH: begin
        if (all_done) state_next = ST_FINISH;
      end
      ST_FINISH: begin
        if (res_load) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    req.ready = (state == ST_IDLE);
    res_load  = (state == ST_FINISH) && (!rsp.valid || rsp.ready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // probe issue tracking and slot rotation
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
      phase      <= SRCH_LB;
    end else if (query_start) begin
      pend_valid <= 1'b0;
      phase      <= SRCH_LB;
    end else if (state == ST_SEARCH) begin
      pend_valid <= issue;
      pend_id    <= phase;
      pend_mid   <= sel_mid;
      case (phase)
        SRCH_LB:  phase <= SRCH_UB;
        SRCH_UB:  phase <= SRCH_HIT;
        default:  phase <= SRCH_LB;
      endcase
    end
  end

  // search windows and partial results
  always_ff @(posedge clk) begin
    if (query_start) begin
      target      <= req.value;
      lo_lb       <= '0;
      lo_ub       <= '0;
      lo_hit      <= '0;
      hi_lb       <= ptr_t'(count) - ptr_t'(1);
      hi_ub       <= ptr_t'(count) - ptr_t'(1);
      hi_hit      <= ptr_t'(count) - ptr_t'(1);
      lb_found    <= 1'b0;
      ub_found    <= 1'b0;
      fl_found    <= 1'b0;
      hit_found   <= 1'b0;
      first_found <= 1'b0;
      last_found  <= 1'b0;
    end else if ((state == ST_SEARCH) && pend_valid) begin
      case (pend_id)
        // go left on element >= target
        SRCH_LB: begin
          if (rdata >= target) begin
            lb_found <= 1'b1;
            lb_idx   <= pend_mid;
            ceil_val <= rdata;
            hi_lb    <= pend_ptr - ptr_t'(1);
          end else begin
            lo_lb <= pend_ptr + ptr_t'(1);
          end
          if (rdata == target) begin
            first_found <= 1'b1;
            first_idx   <= pend_mid;
          end
        end
        // go left on element > target
        SRCH_UB: begin
          if (rdata > target) begin
            ub_found <= 1'b1;
            ub_idx   <= pend_mid;
            hi_ub    <= pend_ptr - ptr_t'(1);
          end else begin
            fl_found  <= 1'b1;
            floor_val <= rdata;
            lo_ub     <= pend_ptr + ptr_t'(1);
          end
          if (rdata == target) begin
            last_found <= 1'b1;
            last_idx   <= pend_mid;
          end
        end
        // plain search, stops on a hit
        SRCH_HIT: begin
          if (rdata == target) begin
            hit_found <= 1'b1;
            hit_idx   <= pend_mid;
          end else if (rdata < target) begin
            lo_hit <= pend_ptr + ptr_t'(1);
          end else begin
            hi_hit <= pend_ptr - ptr_t'(1);
          end
        end
        default: begin
        end
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (res_load) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      rsp.hit_index   <= hit_found ? addr_to_idx(hit_idx) : IDX_NONE;
      rsp.lower_bound <= lb_found ? addr_to_idx(lb_idx) : cnt_idx;
      rsp.upper_bound <= ub_found ? addr_to_idx(ub_idx) : cnt_idx;
      rsp.floor_found <= fl_found;
      rsp.floor_value <= fl_found ? floor_val : '0;
      rsp.ceil_found  <= lb_found;
      rsp.ceil_value  <= lb_found ? ceil_val : '0;
      rsp.first_index <= first_found ? addr_to_idx(first_idx) : IDX_NONE;
      rsp.last_index  <= last_found ? addr_to_idx(last_idx) : IDX_NONE;
      rsp.match_count <= (first_found && last_found)
                         ? (addr_to_idx(last_idx) - addr_to_idx(first_idx) + idx_t'(1))
                         : '0;
    end
  end

endmodule
